### hw/rtl/otle_pkg.sv
`default_nettype none
package otle_pkg;
    localparam int DEPTH = 16;
    localparam int ID_BITS = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        K_APPEND = 3'd0, K_PUSH_HEAD = 3'd1, K_REMOVE_ID = 3'd2,
        K_POP_HEAD = 3'd3, K_LOOKUP = 3'd4, K_NEXT = 3'd5,
        K_NOP6 = 3'd6, K_NOP7 = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0, ST_MISS = 2'd1, ST_EMPTY = 2'd2, ST_FULL = 2'd3
    } t_status;

    typedef enum logic [1:0] {S_IDLE, S_MATCH, S_UPDATE, S_OUT} t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] ticket_id;
        logic [15:0] customer_tag;
        logic [15:0] ride_tag;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] entry_id;
        logic [15:0] entry_customer;
        logic [15:0] entry_ride;
        logic [4:0]  entry_count;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic match;
        logic update;
    } t_cmd;
endpackage
`default_nettype wire

### hw/rtl/otle_if.sv
`default_nettype none
interface otle_req_if;
    logic valid;
    logic ready;
    otle_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface otle_rsp_if;
    logic valid;
    logic ready;
    otle_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/otle_ctrl.sv
`default_nettype none
module otle_ctrl (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output otle_pkg::t_cmd o_cmd
);
    otle_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= otle_pkg::S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_req_ready = 1'b0;
        o_rsp_valid = 1'b0;
        o_cmd = '0;
        unique case (r_state)
            otle_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load = i_req_valid;
                if (i_req_valid) n_state = otle_pkg::S_MATCH;
            end
            otle_pkg::S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state = otle_pkg::S_UPDATE;
            end
            otle_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state = otle_pkg::S_OUT;
            end
            otle_pkg::S_OUT: begin
                o_rsp_valid = 1'b1;
                if (i_rsp_ready) n_state = otle_pkg::S_IDLE;
            end
            default: n_state = otle_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### hw/rtl/otle_dp.sv
`default_nettype none
module otle_dp (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire otle_pkg::t_cmd i_cmd,
    input  wire otle_pkg::t_req i_req,
    output otle_pkg::t_rsp o_rsp
);
    localparam int D = otle_pkg::DEPTH;
    localparam int IW = otle_pkg::IDX_W;
    localparam int CW = otle_pkg::CNT_W;
    localparam int IB = otle_pkg::ID_BITS < 16 ? otle_pkg::ID_BITS : 16;

    logic [15:0] r_ids [D];
    logic [15:0] r_cus [D];
    logic [15:0] r_rds [D];
    logic [CW-1:0] r_fill;
    otle_pkg::t_req r_req;
    logic [D-1:0] r_hit;
    otle_pkg::t_rsp r_rsp;
    otle_pkg::t_rsp n_rsp;

    logic [15:0] w_id;
    logic [D-1:0] w_hit;
    logic [IW-1:0] w_pos;
    logic w_any;
    logic w_full, w_empty;
    logic [IW-1:0] w_rm;
    logic w_do_rm;
    logic [IW-1:0] w_rep;
    logic [IW-1:0] w_nx2;
    logic [CW-1:0] w_fill_n;

    assign w_id = {{(16 - IB){1'b0}}, i_req.ticket_id[IB-1:0]};
    assign w_full = (r_fill == CW'(D));
    assign w_empty = (r_fill == '0);

    // one comparator per slot
    always_comb begin
        for (int k = 0; k < D; k++)
            w_hit[k] = (r_ids[k] == r_req.ticket_id) && (CW'(k) < r_fill);
    end

    // first hit from the head, taken from registered hit vector
    always_comb begin
        w_pos = '0;
        w_any = 1'b0;
        for (int k = D - 1; k >= 0; k--)
            if (r_hit[k]) begin
                w_pos = IW'(k);
                w_any = 1'b1;
            end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= {i_req.kind, w_id, i_req.customer_tag, i_req.ride_tag};
        end
        if (i_cmd.match) begin
            r_hit <= w_hit;
        end
    end

    // update: shift slots and build the response (pos from hit vector)
    assign w_nx2 = ({1'b0, w_pos} + (IW+1)'(1) >= (IW+1)'(r_fill)) ? '0 : w_pos + IW'(1);

    always_comb begin
        w_rm = '0;
        w_do_rm = 1'b0;
        if (!w_empty) begin
            if (r_req.kind == otle_pkg::K_POP_HEAD) w_do_rm = 1'b1;
            if (r_req.kind == otle_pkg::K_REMOVE_ID && w_any) begin
                w_do_rm = 1'b1;
                w_rm = w_pos;
            end
        end
        w_rep = (r_req.kind == otle_pkg::K_NEXT) ? w_nx2 :
                (r_req.kind == otle_pkg::K_POP_HEAD) ? '0 : w_pos;
    end

    always_comb begin
        w_fill_n = r_fill;
        if ((r_req.kind == otle_pkg::K_APPEND || r_req.kind == otle_pkg::K_PUSH_HEAD)
            && !w_full) w_fill_n = r_fill + CW'(1);
        if (w_do_rm) w_fill_n = r_fill - CW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.update) begin
            r_fill <= w_fill_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            if (r_req.kind == otle_pkg::K_APPEND && !w_full) begin
                r_ids[r_fill[IW-1:0]] <= r_req.ticket_id;
                r_cus[r_fill[IW-1:0]] <= r_req.customer_tag;
                r_rds[r_fill[IW-1:0]] <= r_req.ride_tag;
            end else if (r_req.kind == otle_pkg::K_PUSH_HEAD && !w_full) begin
                for (int k = D - 1; k > 0; k--) begin
                    r_ids[k] <= r_ids[k-1];
                    r_cus[k] <= r_cus[k-1];
                    r_rds[k] <= r_rds[k-1];
                end
                r_ids[0] <= r_req.ticket_id;
                r_cus[0] <= r_req.customer_tag;
                r_rds[0] <= r_req.ride_tag;
            end else if (w_do_rm) begin
                for (int k = 0; k < D - 1; k++)
                    if (IW'(k) >= w_rm) begin
                        r_ids[k] <= r_ids[k+1];
                        r_cus[k] <= r_cus[k+1];
                        r_rds[k] <= r_rds[k+1];
                    end
            end
        end
    end

    always_comb begin
        n_rsp = '0;
        n_rsp.entry_count = 5'(w_fill_n);
        if (r_req.kind == otle_pkg::K_APPEND || r_req.kind == otle_pkg::K_PUSH_HEAD) begin
            n_rsp.status = w_full ? otle_pkg::ST_FULL : otle_pkg::ST_DONE;
        end else if (r_req.kind <= otle_pkg::K_NEXT) begin
            if (w_empty) n_rsp.status = otle_pkg::ST_EMPTY;
            else if (r_req.kind != otle_pkg::K_POP_HEAD && !w_any)
                n_rsp.status = otle_pkg::ST_MISS;
            else begin
                n_rsp.status = otle_pkg::ST_DONE;
                n_rsp.entry_id = r_ids[w_rep];
                n_rsp.entry_customer = r_cus[w_rep];
                n_rsp.entry_ride = r_rds[w_rep];
            end
        end else begin
            n_rsp.status = otle_pkg::ST_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;
endmodule
`default_nettype wire

### hw/rtl/ordered_ticket_list_engine.sv
// An accepted request passes through match and update; the response is valid in the out state.
// Requests are not overlapped: each passes through idle, match, update and out, and a stalled
// response holds off the next request.
// The slot compare runs across all entries at once in match; shifts finish in update.
// Reset: synchronous active-low i_rst_n clears the count and controller; slot data
// stays undefined until written.
`default_nettype none
module ordered_ticket_list_engine (
    input wire logic i_clk,
    input wire logic i_rst_n,
    otle_req_if.sink   i_req,
    otle_rsp_if.source o_rsp
);
    otle_pkg::t_cmd w_cmd;

    // controller: sequences load, match and update, then holds the response
    otle_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req.valid), .o_req_ready(i_req.ready),
        .o_rsp_valid(o_rsp.valid), .i_rsp_ready(o_rsp.ready),
        .o_cmd(w_cmd)
    );

    // datapath: slots, fill count, compare and shift
    otle_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .i_req(i_req.data), .o_rsp(o_rsp.data)
    );
endmodule
`default_nettype wire

### hw/rtl/otle_checker.sv
`default_nettype none
module otle_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_req_valid,
    input wire logic i_req_ready,
    input wire logic i_rsp_valid,
    input wire logic i_rsp_ready,
    input wire logic [4:0] i_cnt
);
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req_ready && i_rsp_valid)) else $error("ready during response");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> ##2 i_rsp_valid) else $error("latency");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_cnt <= 5'd16) else $error("count range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid) else $error("drop");
endmodule

bind ordered_ticket_list_engine otle_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_req_valid(i_req.valid), .i_req_ready(i_req.ready),
    .i_rsp_valid(o_rsp.valid), .i_rsp_ready(o_rsp.ready),
    .i_cnt(o_rsp.data.entry_count)
);
`default_nettype wire
